// ----- hw/rtl/line_segment_clipper_unit_defines.svh -----
// assertion macros for the line segment clipper
`ifndef LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH
`define LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH

// clocked check, quiet during reset
`define LSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication in the same cycle
`define LSC_ASSERT_IMP(lbl, ante, cons, msg) \
  `LSC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- hw/rtl/lsc_pkg.sv -----
`timescale 1ns / 1ps
package lsc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 24;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int REM_BITS   = MAG_BITS + 1;
  localparam int Q_BITS     = FRAC_BITS + 1;
  localparam int U_BITS     = FRAC_BITS + 2;
  localparam int QB_PER_ST  = 5;
  localparam int DIV_STAGES = (Q_BITS + QB_PER_ST - 1) / QB_PER_ST;
  localparam int PROD_BITS  = MAG_BITS + Q_BITS;
  localparam int SUM_BITS   = DIFF_BITS + 1;
  localparam int LANES      = 4;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_A_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_A_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_B_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_B_Y = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [MAG_BITS-1:0]          mag_t;
  typedef logic [REM_BITS-1:0]          rem_t;
  typedef logic [Q_BITS-1:0]            quo_t;
  typedef logic [U_BITS-1:0]            u_t;

  localparam u_t U_ONE = u_t'(1) << FRAC_BITS;
  localparam u_t U_TWO = u_t'(1) << (FRAC_BITS + 1);

  typedef struct packed {
    logic sat;
    logic neg;
  } rflag_t;

  typedef struct packed {
    logic zero;
    logic zrej;
    logic enter;
  } lane_ctl_t;

  typedef struct packed {
    coord_t                 x1;
    coord_t                 y1;
    diff_t                  dx;
    diff_t                  dy;
    lane_ctl_t [LANES-1:0]  ctl;
  } side_t;

endpackage

// ----- hw/rtl/lsc_div.sv -----
`timescale 1ns / 1ps
module lsc_div
  import lsc_pkg::*;
(
  input  logic   clk,
  input  mag_t   aq,
  input  mag_t   ap,
  input  rflag_t in_flags,
  output u_t     ratio,
  output rflag_t out_flags
);

  rem_t   rem_r   [DIV_STAGES];
  quo_t   quo_r   [DIV_STAGES];
  mag_t   ap_r    [DIV_STAGES];
  rflag_t flags_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    rem_t   rem_in;
    quo_t   quo_in;
    mag_t   ap_in;
    rflag_t fl_in;
    rem_t   rem_v;
    quo_t   quo_v;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, aq};
      assign quo_in = '0;
      assign ap_in  = ap;
      assign fl_in  = in_flags;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign ap_in  = ap_r[k-1];
      assign fl_in  = flags_r[k-1];
    end

    always_comb begin
      logic ge;
      rem_v = rem_in;
      quo_v = quo_in;
      for (int i = 0; i < QB_PER_ST; i++) begin
        if (k * QB_PER_ST + i < Q_BITS) begin
          ge = rem_v >= {1'b0, ap_in};
          if (ge) rem_v = rem_v - {1'b0, ap_in};
          quo_v = {quo_v[Q_BITS-2:0], ge};
          rem_v = {rem_v[REM_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]   <= rem_v;
      quo_r[k]   <= quo_v;
      ap_r[k]    <= ap_in;
      flags_r[k] <= fl_in;
    end
  end

  assign out_flags = flags_r[DIV_STAGES-1];
  assign ratio     = out_flags.sat ? U_TWO : {1'b0, quo_r[DIV_STAGES-1]};

endmodule

// ----- hw/rtl/lsc_lerp.sv -----
`timescale 1ns / 1ps
module lsc_lerp
  import lsc_pkg::*;
(
  input  logic   clk,
  input  coord_t s,
  input  diff_t  d,
  input  quo_t   u,
  output coord_t res
);

  logic [PROD_BITS-1:0] prod_r;
  coord_t               s_r;
  logic                 dneg_r;
  coord_t               res_r;

  diff_t                dabs;
  logic [PROD_BITS-1:0] prod_nxt;
  logic [DIFF_BITS-1:0] m;
  logic                 frac;
  logic signed [SUM_BITS-1:0] base;
  logic signed [SUM_BITS-1:0] res_nxt;

  assign dabs     = d[DIFF_BITS-1] ? -d : d;
  assign prod_nxt = PROD_BITS'(dabs[MAG_BITS-1:0]) * PROD_BITS'(u);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    s_r    <= s;
    dneg_r <= d[DIFF_BITS-1];
  end

  assign m    = DIFF_BITS'(prod_r[PROD_BITS-1:FRAC_BITS]);
  assign frac = |prod_r[FRAC_BITS-1:0];

  always_comb begin
    if (!dneg_r) begin
      base = SUM_BITS'(s_r) + $signed({1'b0, m});
      res_nxt = (base < 0 && frac) ? base + SUM_BITS'(1) : base;
    end else begin
      base = SUM_BITS'(s_r) - $signed({1'b0, m});
      res_nxt = (frac && base >= SUM_BITS'(1)) ? base - SUM_BITS'(1) : base;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt[COORD_BITS-1:0];
  end

  assign res = res_r;

endmodule

// ----- hw/rtl/line_segment_clipper_unit.sv -----
`timescale 1ns / 1ps
`include "line_segment_clipper_unit_defines.svh"
// Liang-Barsky line segment clipper.
// Window: write the two corners on the cfg channel (index 0..3 = a_x, a_y,
// b_x, b_y); cfg_ready is always high. Corners may be given in any order.
// Only rewrite the window while no item is in flight.
// Input: a segment is taken at each clock edge with start high; busy is
// always low, so one segment per cycle is accepted.
// Output: out_valid is high for one cycle per segment, ten register stages
// after the accepting edge, in input order. out_rejected marks
// a segment fully outside the window; its coordinates then read zero.
// Pipeline, in order: deltas; magnitudes and flags; the divider stages
// (five quotient bits per stage, four dividers in parallel); merge of
// the entry/exit parameters; multiply and final sum.
// Reset clears the window registers and all valid bits; items in flight
// are dropped. The receiver cannot stall; results must be taken as shown.
module line_segment_clipper_unit
  import lsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  coord_t                  in_start_x,
  input  coord_t                  in_start_y,
  input  coord_t                  in_end_x,
  input  coord_t                  in_end_y,
  output logic                    out_valid,
  output logic                    out_rejected,
  output coord_t                  out_clip_start_x,
  output coord_t                  out_clip_start_y,
  output coord_t                  out_clip_end_x,
  output coord_t                  out_clip_end_y,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  coord_t                  cfg_data
);

  coord_t ax_r, ay_r, bx_r, by_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_A_X: ax_r <= cfg_data;
        CFG_A_Y: ay_r <= cfg_data;
        CFG_B_X: bx_r <= cfg_data;
        CFG_B_Y: by_r <= cfg_data;
        default: ;
      endcase
    end
  end

  coord_t xmin, xmax, ymin, ymax;
  assign xmin = (ax_r < bx_r) ? ax_r : bx_r;
  assign xmax = (ax_r < bx_r) ? bx_r : ax_r;
  assign ymin = (ay_r < by_r) ? ay_r : by_r;
  assign ymax = (ay_r < by_r) ? by_r : ay_r;

  // stage 1: deltas and boundary distances
  logic   s1_vld_r;
  coord_t s1_x1_r, s1_y1_r;
  diff_t  s1_dx_r, s1_dy_r;
  diff_t  s1_q_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_x1_r  <= in_start_x;
    s1_y1_r  <= in_start_y;
    s1_dx_r  <= DIFF_BITS'(in_end_x) - DIFF_BITS'(in_start_x);
    s1_dy_r  <= DIFF_BITS'(in_end_y) - DIFF_BITS'(in_start_y);
    s1_q_r[0] <= DIFF_BITS'(in_start_x) - DIFF_BITS'(xmin);
    s1_q_r[1] <= DIFF_BITS'(xmax) - DIFF_BITS'(in_start_x);
    s1_q_r[2] <= DIFF_BITS'(in_start_y) - DIFF_BITS'(ymin);
    s1_q_r[3] <= DIFF_BITS'(ymax) - DIFF_BITS'(in_start_y);
  end

  // stage 2: magnitudes, signs, saturation
  diff_t s1_p [LANES];
  assign s1_p[0] = -s1_dx_r;
  assign s1_p[1] = s1_dx_r;
  assign s1_p[2] = -s1_dy_r;
  assign s1_p[3] = s1_dy_r;

  logic   s2_vld_r;
  side_t  s2_side_r;
  mag_t   s2_aq_r [LANES];
  mag_t   s2_ap_r [LANES];
  rflag_t s2_fl_r [LANES];

  lane_ctl_t [LANES-1:0] s1_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    diff_t aq_f, ap_f;
    logic  pneg, qneg, pz;
    assign pneg = s1_p[l][DIFF_BITS-1];
    assign qneg = s1_q_r[l][DIFF_BITS-1];
    assign pz   = (s1_p[l] == '0);
    assign aq_f = qneg ? -s1_q_r[l] : s1_q_r[l];
    assign ap_f = pneg ? -s1_p[l] : s1_p[l];
    assign s1_ctl[l] = '{zero: pz, zrej: pz && qneg, enter: pneg};

    always_ff @(posedge clk) begin
      s2_aq_r[l]            <= aq_f[MAG_BITS-1:0];
      s2_ap_r[l]            <= ap_f[MAG_BITS-1:0];
      s2_fl_r[l].neg        <= (s1_q_r[l] != '0) && (qneg != pneg);
      s2_fl_r[l].sat        <= {1'b0, aq_f[MAG_BITS-1:0]} >= {ap_f[MAG_BITS-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r.x1  <= s1_x1_r;
    s2_side_r.y1  <= s1_y1_r;
    s2_side_r.dx  <= s1_dx_r;
    s2_side_r.dy  <= s1_dy_r;
    s2_side_r.ctl <= s1_ctl;
  end

  // divider stages
  u_t     dv_ratio [LANES];
  rflag_t dv_fl    [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_div
    lsc_div u_div (
      .clk       (clk),
      .aq        (s2_aq_r[l]),
      .ap        (s2_ap_r[l]),
      .in_flags  (s2_fl_r[l]),
      .ratio     (dv_ratio[l]),
      .out_flags (dv_fl[l])
    );
  end

  logic [DIV_STAGES-1:0] dl_vld_r;
  side_t                 dl_side_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) dl_vld_r <= '0;
    else        dl_vld_r <= {dl_vld_r[DIV_STAGES-2:0], s2_vld_r};
  end

  always_ff @(posedge clk) begin
    dl_side_r[0] <= s2_side_r;
    for (int i = 1; i < DIV_STAGES; i++) dl_side_r[i] <= dl_side_r[i-1];
  end

  side_t dv_side;
  assign dv_side = dl_side_r[DIV_STAGES-1];

  // stage 3: entry/exit parameters and reject
  u_t   u1_nxt, u2_nxt;
  logic rej_nxt;

  always_comb begin
    u1_nxt  = '0;
    u2_nxt  = U_ONE;
    rej_nxt = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (dv_side.ctl[l].zero) begin
        if (dv_side.ctl[l].zrej) rej_nxt = 1'b1;
      end else if (dv_side.ctl[l].enter) begin
        if (!dv_fl[l].neg && dv_ratio[l] > u1_nxt) u1_nxt = dv_ratio[l];
      end else begin
        if (dv_fl[l].neg) rej_nxt = 1'b1;
        else if (dv_ratio[l] < u2_nxt) u2_nxt = dv_ratio[l];
      end
    end
    if (u1_nxt > u2_nxt) rej_nxt = 1'b1;
  end

  logic   s3_vld_r, s3_rej_r;
  u_t     s3_u1_r, s3_u2_r;
  coord_t s3_x1_r, s3_y1_r;
  diff_t  s3_dx_r, s3_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= dl_vld_r[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    s3_rej_r <= rej_nxt;
    s3_u1_r  <= u1_nxt;
    s3_u2_r  <= u2_nxt;
    s3_x1_r  <= dv_side.x1;
    s3_y1_r  <= dv_side.y1;
    s3_dx_r  <= dv_side.dx;
    s3_dy_r  <= dv_side.dy;
  end

  // stages 4-5: interpolation
  coord_t r_sx, r_sy, r_ex, r_ey;

  lsc_lerp u_lerp_sx (.clk(clk), .s(s3_x1_r), .d(s3_dx_r),
                      .u(s3_u1_r[Q_BITS-1:0]), .res(r_sx));
  lsc_lerp u_lerp_sy (.clk(clk), .s(s3_y1_r), .d(s3_dy_r),
                      .u(s3_u1_r[Q_BITS-1:0]), .res(r_sy));
  lsc_lerp u_lerp_ex (.clk(clk), .s(s3_x1_r), .d(s3_dx_r),
                      .u(s3_u2_r[Q_BITS-1:0]), .res(r_ex));
  lsc_lerp u_lerp_ey (.clk(clk), .s(s3_y1_r), .d(s3_dy_r),
                      .u(s3_u2_r[Q_BITS-1:0]), .res(r_ey));

  logic [1:0] ot_vld_r;
  logic [1:0] ot_rej_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ot_vld_r <= '0;
    else        ot_vld_r <= {ot_vld_r[0], s3_vld_r};
  end

  always_ff @(posedge clk) begin
    ot_rej_r <= {ot_rej_r[0], s3_rej_r};
  end

  assign out_valid        = ot_vld_r[1];
  assign out_rejected     = ot_rej_r[1];
  assign out_clip_start_x = ot_rej_r[1] ? '0 : r_sx;
  assign out_clip_start_y = ot_rej_r[1] ? '0 : r_sy;
  assign out_clip_end_x   = ot_rej_r[1] ? '0 : r_ex;
  assign out_clip_end_y   = ot_rej_r[1] ? '0 : r_ey;

  `LSC_ASSERT_IMP(a_u_order, s3_vld_r && !s3_rej_r, s3_u1_r <= s3_u2_r && s3_u2_r <= U_ONE, "kept segment has bad parameters")
  `LSC_ASSERT_IMP(a_out_follows, out_valid, $past(s3_vld_r, 2), "result without an item")
  `LSC_ASSERT(a_sat_rejects, s3_vld_r && s3_u1_r > U_ONE |-> s3_rej_r, "saturated entry kept")

endmodule
